>>> sv/smi_pkg.sv
// shared types and constants for the switch management master
// no dependencies; imported by smi_seq and smi_switch_register_master_top
package smi_pkg;

    localparam logic [7:0] CMD_READ  = 8'ha9;
    localparam logic [7:0] CMD_WRITE = 8'hb8;

    localparam logic [1:0] REQ_NONE        = 2'd0;
    localparam logic [1:0] REQ_READ        = 2'd1;
    localparam logic [1:0] REQ_WRITE       = 2'd2;
    localparam logic [1:0] REQ_WRITE_NOACK = 2'd3;

    localparam logic [2:0] BYTE_CMD     = 3'd0;
    localparam logic [2:0] BYTE_ADDR_LO = 3'd1;
    localparam logic [2:0] BYTE_ADDR_HI = 3'd2;
    localparam logic [2:0] BYTE_DATA_LO = 3'd3;
    localparam logic [2:0] BYTE_DATA_HI = 3'd4;
    localparam logic [2:0] BYTE_END     = 3'd5;

    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_W_DATA   = 4'd2,
        PH_W_CLKH   = 4'd3,
        PH_W_CLKL   = 4'd4,
        PH_ACK_CLKH = 4'd5,
        PH_ACK_SAMP = 4'd6,
        PH_R_CLKH   = 4'd7,
        PH_R_SAMP   = 4'd8,
        PH_A_DATA   = 4'd9,
        PH_A_CLKH   = 4'd10,
        PH_A_CLKL   = 4'd11,
        PH_STOP     = 4'd12
    } phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] reg_address;
        logic [15:0] write_value;
        logic        mdio_sample;
    } tick_t;

    typedef struct packed {
        logic        clock_level;
        logic        data_level;
        logic        data_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_result;
        logic        status;
    } res_t;

endpackage

>>> sv/smi_seq.sv
// transaction sequencer: holds the bus state and advances by one step per tick word
// depends on smi_pkg
module smi_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  smi_pkg::tick_t tick,
    input  logic [3:0]    retry_limit,
    output smi_pkg::res_t res
);
    import smi_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [15:0] shift_data_reg, shift_data_next;
    logic [3:0]  retry_count_reg, retry_count_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] wval_reg, wval_next;
    logic        err_reg, err_next;
    logic        clk_line_reg, clk_line_next;
    logic        dat_line_reg, dat_line_next;
    logic        drv_line_reg, drv_line_next;

    logic [7:0]  cur_byte;
    logic [2:0]  byte_inc;
    logic [3:0]  rd_pos;
    logic        busy;
    logic        done;
    logic [15:0] rd;
    logic        st;

    always_comb
    begin
        case (byte_index_reg)
            BYTE_CMD:     cur_byte = (kind_reg == REQ_READ) ? CMD_READ : CMD_WRITE;
            BYTE_ADDR_LO: cur_byte = addr_reg[7:0];
            BYTE_ADDR_HI: cur_byte = addr_reg[15:8];
            BYTE_DATA_LO: cur_byte = wval_reg[7:0];
            BYTE_DATA_HI: cur_byte = wval_reg[15:8];
            default:      cur_byte = 8'h00;
        endcase
    end

    assign byte_inc = byte_index_reg + 3'd1;
    // second read byte lands in the upper half
    assign rd_pos = {(byte_index_reg >= BYTE_DATA_HI), bit_count_reg[2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            byte_index_reg  <= '0;
            shift_data_reg  <= '0;
            retry_count_reg <= '0;
            kind_reg        <= REQ_NONE;
            addr_reg        <= '0;
            wval_reg        <= '0;
            err_reg         <= 1'b0;
            clk_line_reg    <= 1'b0;
            dat_line_reg    <= 1'b0;
            drv_line_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            byte_index_reg  <= byte_index_next;
            shift_data_reg  <= shift_data_next;
            retry_count_reg <= retry_count_next;
            kind_reg        <= kind_next;
            addr_reg        <= addr_next;
            wval_reg        <= wval_next;
            err_reg         <= err_next;
            clk_line_reg    <= clk_line_next;
            dat_line_reg    <= dat_line_next;
            drv_line_reg    <= drv_line_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        byte_index_next  = byte_index_reg;
        shift_data_next  = shift_data_reg;
        retry_count_next = retry_count_reg;
        kind_next        = kind_reg;
        addr_next        = addr_reg;
        wval_next        = wval_reg;
        err_next         = err_reg;
        clk_line_next    = clk_line_reg;
        dat_line_next    = dat_line_reg;
        drv_line_next    = drv_line_reg;
        busy             = 1'b1;
        done             = 1'b0;
        rd               = 16'h0000;
        st               = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                case (bit_count_reg)
                    4'd0: clk_line_next = 1'b1;
                    4'd1: clk_line_next = 1'b0;
                    4'd2: clk_line_next = 1'b1;
                    4'd3:
                    begin
                        dat_line_next = 1'b0;
                        drv_line_next = 1'b1;
                    end
                    4'd4: clk_line_next = 1'b0;
                    default:
                    begin
                        dat_line_next = 1'b1;
                        drv_line_next = 1'b1;
                    end
                endcase
                if (bit_count_reg >= 4'd5)
                begin
                    phase_next     = PH_W_DATA;
                    bit_count_next = 4'd7;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
            end
            PH_W_DATA:
            begin
                dat_line_next = cur_byte[bit_count_reg[2:0]];
                drv_line_next = 1'b1;
                phase_next    = PH_W_CLKH;
            end
            PH_W_CLKH:
            begin
                clk_line_next = 1'b1;
                phase_next    = PH_W_CLKL;
            end
            PH_W_CLKL:
            begin
                clk_line_next = 1'b0;
                if (bit_count_reg != 4'd0)
                begin
                    bit_count_next = bit_count_reg - 4'd1;
                    phase_next     = PH_W_DATA;
                end
                else if (kind_reg == REQ_WRITE_NOACK && byte_index_reg >= BYTE_DATA_HI)
                begin
                    phase_next     = PH_STOP;
                    bit_count_next = 4'd0;
                end
                else
                begin
                    drv_line_next    = 1'b0;
                    retry_count_next = 4'd0;
                    phase_next       = PH_ACK_CLKH;
                end
            end
            PH_ACK_CLKH:
            begin
                clk_line_next = 1'b1;
                phase_next    = PH_ACK_SAMP;
            end
            PH_ACK_SAMP:
            begin
                clk_line_next = 1'b0;
                if (!tick.mdio_sample)
                begin
                    drv_line_next   = 1'b1;
                    dat_line_next   = 1'b0;
                    byte_index_next = byte_inc;
                    if (kind_reg == REQ_READ && byte_inc >= BYTE_DATA_LO)
                    begin
                        drv_line_next  = 1'b0;
                        bit_count_next = 4'd7;
                        phase_next     = PH_R_CLKH;
                    end
                    else if (byte_inc >= BYTE_END)
                    begin
                        phase_next     = PH_STOP;
                        bit_count_next = 4'd0;
                    end
                    else
                    begin
                        bit_count_next = 4'd7;
                        phase_next     = PH_W_DATA;
                    end
                end
                else if (retry_count_reg >= retry_limit)
                begin
                    // ack timeout: abort through the stop pattern
                    err_next       = 1'b1;
                    drv_line_next  = 1'b1;
                    dat_line_next  = 1'b0;
                    phase_next     = PH_STOP;
                    bit_count_next = 4'd0;
                end
                else
                begin
                    retry_count_next = retry_count_reg + 4'd1;
                    phase_next       = PH_ACK_CLKH;
                end
            end
            PH_R_CLKH:
            begin
                clk_line_next = 1'b1;
                phase_next    = PH_R_SAMP;
            end
            PH_R_SAMP:
            begin
                clk_line_next           = 1'b0;
                shift_data_next[rd_pos] = shift_data_reg[rd_pos] | tick.mdio_sample;
                if (bit_count_reg != 4'd0)
                begin
                    bit_count_next = bit_count_reg - 4'd1;
                    phase_next     = PH_R_CLKH;
                end
                else
                begin
                    drv_line_next = 1'b1;
                    dat_line_next = 1'b0;
                    phase_next    = PH_A_DATA;
                end
            end
            PH_A_DATA:
            begin
                // ack 0 after the low byte, 1 after the high byte
                dat_line_next = (byte_index_reg >= BYTE_DATA_HI);
                drv_line_next = 1'b1;
                phase_next    = PH_A_CLKH;
            end
            PH_A_CLKH:
            begin
                clk_line_next = 1'b1;
                phase_next    = PH_A_CLKL;
            end
            PH_A_CLKL:
            begin
                clk_line_next = 1'b0;
                if (byte_index_reg < BYTE_DATA_HI)
                begin
                    byte_index_next = BYTE_DATA_HI;
                    drv_line_next   = 1'b0;
                    bit_count_next  = 4'd7;
                    phase_next      = PH_R_CLKH;
                end
                else
                begin
                    phase_next     = PH_STOP;
                    bit_count_next = 4'd0;
                end
            end
            PH_STOP:
            begin
                case (bit_count_reg)
                    4'd0:
                    begin
                        dat_line_next = 1'b0;
                        drv_line_next = 1'b1;
                        clk_line_next = 1'b1;
                    end
                    4'd1: dat_line_next = 1'b1;
                    4'd2: clk_line_next = 1'b1;
                    4'd3: clk_line_next = 1'b0;
                    4'd4: clk_line_next = 1'b1;
                    4'd5: clk_line_next = 1'b0;
                    default:
                    begin
                        clk_line_next = 1'b0;
                        dat_line_next = 1'b0;
                        drv_line_next = 1'b0;
                    end
                endcase
                if (bit_count_reg >= 4'd6)
                begin
                    done = 1'b1;
                    st   = err_reg;
                    if (kind_reg == REQ_READ && !err_reg)
                    begin
                        rd = shift_data_reg;
                    end
                    phase_next     = PH_IDLE;
                    bit_count_next = 4'd0;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                end
            end
            default:
            begin
                phase_next    = PH_IDLE;
                clk_line_next = 1'b0;
                dat_line_next = 1'b0;
                drv_line_next = 1'b0;
                if (tick.req_type != REQ_NONE)
                begin
                    kind_next        = tick.req_type;
                    addr_next        = tick.reg_address;
                    wval_next        = tick.write_value;
                    bit_count_next   = 4'd0;
                    byte_index_next  = BYTE_CMD;
                    shift_data_next  = 16'h0000;
                    retry_count_next = 4'd0;
                    err_next         = 1'b0;
                    dat_line_next    = 1'b1;
                    drv_line_next    = 1'b1;
                    phase_next       = PH_START;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        res.clock_level = clk_line_next;
        res.data_level  = drv_line_next & dat_line_next;
        res.data_drive  = drv_line_next;
        res.busy_res    = busy;
        res.done_res    = done;
        res.read_result = rd;
        res.status      = st;
    end

endmodule

>>> sv/smi_switch_register_master_top.sv
// top level of the switch management master: input word register, sequencer, result register
// depends on smi_pkg and smi_seq
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tick word: request, address, data, sample
//  m_*      | out | m_tvalid/m_tready  | line levels, busy, done, read data, status
//  cfg_*    | in  | cfg_valid/cfg_ready| ack retry limit
//
//  one tick word per clock while m_tready does not stall the result register; a word
//  passes the input register, then the sequencer step, and lands in the result register
//  reset leaves the sequencer idle with the clock line low and data released
//  a stall on m_tready holds the result register, then the input register, and
//  only then drops s_tready; the sequencer steps only when a word moves forward
module smi_switch_register_master_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // reg_address[15:0], write_value[31:16], mdio_sample[32], zero fill
    input  logic [smi_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // clock_level[0], data_level[1], data_drive[2], busy_res[3], done_res[4],
    // read_result[20:5], status[21], zero fill
    output logic [smi_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [3:0]                          cfg_data
);
    import smi_pkg::*;

    logic       in_valid_reg;
    tick_t      in_word_reg;
    logic       out_valid_reg;
    res_t       out_word_reg;
    logic [3:0] retry_limit_reg;
    logic       advance;
    res_t       step_res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            retry_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg.req_type    <= s_tuser;
            in_word_reg.reg_address <= s_tdata[15:0];
            in_word_reg.write_value <= s_tdata[31:16];
            in_word_reg.mdio_sample <= s_tdata[32];
        end
    end

    smi_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .tick        (in_word_reg),
        .retry_limit (retry_limit_reg),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_word_reg.status,
                       out_word_reg.read_result,
                       out_word_reg.done_res,
                       out_word_reg.busy_res,
                       out_word_reg.data_drive,
                       out_word_reg.data_level,
                       out_word_reg.clock_level};

    // a word leaves the input register only into a free result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result register overwritten while stalled");

    // a done result always comes out of a busy tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.done_res) |-> step_res.busy_res)
        else $error("done without busy");

    // status and read data stay zero off the done tick
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !step_res.done_res) |->
            (!step_res.status && step_res.read_result == 16'h0000))
        else $error("status or read data outside done");

    // a released line never reports a driven level
    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !step_res.data_drive) |-> !step_res.data_level)
        else $error("data level high while released");

endmodule
